/* hdl/skt_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the sorted key table.
`timescale 1ns / 1ps

package skt_pkg;

    // Table geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 16;
    localparam int ENTRY_W  = KEY_W + PAY_W;
    localparam int OP_W     = 3;
    localparam int STAT_W   = 2;
    localparam int ECNT_W   = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_MODIFY = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISSING   = 2'd1;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    // Index counter operations
    localparam logic [2:0] IDX_HOLD  = 3'd0;
    localparam logic [2:0] IDX_INC   = 3'd1;
    localparam logic [2:0] IDX_DEC   = 3'd2;
    localparam logic [2:0] IDX_COUNT = 3'd3;
    localparam logic [2:0] IDX_POS   = 3'd4;

    // Memory read address select
    localparam logic [1:0] RD_IDX    = 2'd0;
    localparam logic [1:0] RD_IDX_M1 = 2'd1;
    localparam logic [1:0] RD_IDX_P1 = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic               load_in;
        logic [2:0]         idx_op;
        logic               set_pos;
        logic               hit_val;
        logic               rd_en;
        logic [1:0]         rd_sel;
        logic               wr_en;
        logic               wr_shift;
        logic               cnt_inc;
        logic               cnt_dec;
        logic               cnt_clr;
        logic               res_load;
        logic [STAT_W-1:0]  res_status;
        logic               res_found;
        logic               out_load;
    } skt_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            hit;
        logic            idx_at_count;
        logic            idx_at_pos;
        logic            dn_last;
        logic            key_eq;
        logic            key_gt;
        logic            full;
        logic            empty;
        logic            out_busy;
    } skt_sts_t;

endpackage

/* hdl/sorted_key_table.sv */
// Top level of the sorted key table: controller and datapath joined by command and status.
//
// A table of up to CAPACITY entries (signed 32-bit key, 16-bit payload) kept in
// ascending key order. Operations: insert, modify, delete, clear all, lookup.
// Input channel: in_valid / in_stall with opcode, key, payload. An item is taken
// on a rising edge with in_valid high and in_stall low; in_stall is high while
// an operation is in progress.
// Output channel: out_valid / out_stall with status, found_payload, entry_count.
// One result per item. A result stays in the output register until taken; the
// next item is accepted meanwhile, and its result waits until the register frees.
// Sequencing: the search reads one entry at a time through the single memory
// read port, alternating a read state and a compare state, and each shift moves
// one entry per read and write state pair. Clear and unused opcodes go straight
// from decode to the result state. Insert shifts entries up from the top of the
// table down to the insert position; delete shifts entries down, starting where
// the search stopped.
// Reset empties the table (count to zero) and drops any pending result; entry
// memory is not cleared, since entries above the count are never read.
`timescale 1ns / 1ps

module sorted_key_table
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [skt_pkg::OP_W-1:0]            opcode,
    input  logic signed [skt_pkg::KEY_W-1:0]    key,
    input  logic [skt_pkg::PAY_W-1:0]           payload,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [skt_pkg::STAT_W-1:0]          status,
    output logic [skt_pkg::PAY_W-1:0]           found_payload,
    output logic [skt_pkg::ECNT_W-1:0]          entry_count
);

    skt_pkg::skt_cmd_t cmd;
    skt_pkg::skt_sts_t sts;

    skt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    skt_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .opcode        (opcode),
        .key           (key),
        .payload       (payload),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .found_payload (found_payload),
        .entry_count   (entry_count)
    );

endmodule

/* hdl/skt_datapath.sv */
// Datapath of the sorted key table: entry memory, index and count registers, result register.
`timescale 1ns / 1ps

module skt_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  skt_pkg::skt_cmd_t                   cmd,
    output skt_pkg::skt_sts_t                   sts,
    input  logic [skt_pkg::OP_W-1:0]            opcode,
    input  logic signed [skt_pkg::KEY_W-1:0]    key,
    input  logic [skt_pkg::PAY_W-1:0]           payload,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [skt_pkg::STAT_W-1:0]          status,
    output logic [skt_pkg::PAY_W-1:0]           found_payload,
    output logic [skt_pkg::ECNT_W-1:0]          entry_count
);

    logic [skt_pkg::ENTRY_W-1:0] mem [skt_pkg::CAPACITY];
    logic [skt_pkg::ENTRY_W-1:0] rd_data_reg;

    logic [skt_pkg::OP_W-1:0]    op_reg;
    logic [skt_pkg::KEY_W-1:0]   key_reg;
    logic [skt_pkg::PAY_W-1:0]   pay_reg;

    logic [skt_pkg::CNT_W-1:0]   idx_reg;
    logic [skt_pkg::CNT_W-1:0]   idx_next;
    logic [skt_pkg::CNT_W-1:0]   pos_reg;
    logic                        hit_reg;
    logic [skt_pkg::CNT_W-1:0]   count_reg;
    logic [skt_pkg::CNT_W-1:0]   count_next;

    logic [skt_pkg::STAT_W-1:0]  res_status_reg;
    logic [skt_pkg::PAY_W-1:0]   res_found_reg;

    logic                        out_valid_reg;
    logic [skt_pkg::STAT_W-1:0]  status_reg;
    logic [skt_pkg::PAY_W-1:0]   found_reg;
    logic [skt_pkg::ECNT_W-1:0]  ecnt_reg;

    logic [skt_pkg::IDX_W-1:0]   rd_addr;
    logic [skt_pkg::IDX_W-1:0]   wr_addr;
    logic [skt_pkg::ENTRY_W-1:0] wr_data;
    logic [skt_pkg::CNT_W:0]     idx_plus1;
    logic signed [skt_pkg::KEY_W-1:0] rd_key;

    // Select the read address
    always_comb
    begin
        case (cmd.rd_sel)
            skt_pkg::RD_IDX_M1: rd_addr = skt_pkg::IDX_W'(idx_reg - 1'b1);
            skt_pkg::RD_IDX_P1: rd_addr = skt_pkg::IDX_W'(idx_reg + 1'b1);
            default:            rd_addr = skt_pkg::IDX_W'(idx_reg);
        endcase
    end

    // Select write address and data: new entry at the found position, or a shifted entry
    assign wr_addr = cmd.wr_shift ? skt_pkg::IDX_W'(idx_reg) : skt_pkg::IDX_W'(pos_reg);
    assign wr_data = cmd.wr_shift ? rd_data_reg : {key_reg, pay_reg};

    // Entry memory with registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Capture the input item and results
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg  <= opcode;
            key_reg <= key;
            pay_reg <= payload;
        end
        if (cmd.set_pos)
        begin
            pos_reg <= idx_reg;
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_found_reg  <= cmd.res_found ? rd_data_reg[skt_pkg::PAY_W-1:0] : '0;
        end
        if (cmd.out_load)
        begin
            status_reg <= res_status_reg;
            found_reg  <= res_found_reg;
            ecnt_reg   <= skt_pkg::ECNT_W'(count_reg);
        end
    end

    // Advance the index counter
    always_comb
    begin
        case (cmd.idx_op)
            skt_pkg::IDX_INC:   idx_next = idx_reg + 1'b1;
            skt_pkg::IDX_DEC:   idx_next = idx_reg - 1'b1;
            skt_pkg::IDX_COUNT: idx_next = count_reg;
            skt_pkg::IDX_POS:   idx_next = pos_reg;
            default:            idx_next = idx_reg;
        endcase
        if (cmd.load_in)
        begin
            idx_next = '0;
        end
    end

    // Update the entry count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_clr)
        begin
            count_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
            if (cmd.set_pos)
            begin
                hit_reg <= cmd.hit_val;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Report status to the controller
    assign rd_key    = rd_data_reg[skt_pkg::ENTRY_W-1:skt_pkg::PAY_W];
    assign idx_plus1 = {1'b0, idx_reg} + 1'b1;

    always_comb
    begin
        sts.op           = op_reg;
        sts.hit          = hit_reg;
        sts.idx_at_count = (idx_reg == count_reg);
        sts.idx_at_pos   = (idx_reg == pos_reg);
        sts.dn_last      = (idx_plus1 >= {1'b0, count_reg});
        sts.key_eq       = (rd_key == $signed(key_reg));
        sts.key_gt       = (rd_key > $signed(key_reg));
        sts.full         = (count_reg >= skt_pkg::CNT_W'(skt_pkg::CAPACITY));
        sts.empty        = (count_reg == '0);
        sts.out_busy     = out_valid_reg && out_stall;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign found_payload = found_reg;
    assign entry_count   = ecnt_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= skt_pkg::CNT_W'(skt_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("result register loaded while held by receiver");

    a_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> !sts.full)
        else $error("insert committed into full table");

    a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> !sts.empty && hit_reg)
        else $error("delete committed without a hit");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && cmd.wr_shift) |-> idx_reg < count_reg || cmd.idx_op == skt_pkg::IDX_DEC)
        else $error("shift write outside the table");
`endif

endmodule

/* hdl/skt_ctrl.sv */
// Controller state machine of the sorted key table: search, shift and result sequencing.
`timescale 1ns / 1ps

module skt_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  skt_pkg::skt_sts_t  sts,
    output skt_pkg::skt_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_SRCH_RD  = 4'd2;
    localparam logic [3:0] S_SRCH_CMP = 4'd3;
    localparam logic [3:0] S_ACT      = 4'd4;
    localparam logic [3:0] S_UP_RD    = 4'd5;
    localparam logic [3:0] S_UP_WR    = 4'd6;
    localparam logic [3:0] S_DN_RD    = 4'd7;
    localparam logic [3:0] S_DN_WR    = 4'd8;
    localparam logic [3:0] S_RESULT   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.op) inside
                    skt_pkg::OP_INSERT, skt_pkg::OP_MODIFY,
                    skt_pkg::OP_DELETE, skt_pkg::OP_LOOKUP:
                    begin
                        state_next = S_SRCH_RD;
                    end
                    skt_pkg::OP_CLEAR:
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.cnt_clr    = !sts.empty;
                        cmd.res_status = sts.empty ? skt_pkg::ST_MISSING : skt_pkg::ST_DONE;
                        state_next     = S_RESULT;
                    end
                    default:
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = skt_pkg::ST_MISSING;
                        state_next     = S_RESULT;
                    end
                endcase
            end
            // Walk entries in key order until a key at or above the target, or the end of the table
            S_SRCH_RD:
            begin
                if (sts.idx_at_count)
                begin
                    cmd.set_pos = 1'b1;
                    cmd.hit_val = 1'b0;
                    state_next  = S_ACT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = skt_pkg::RD_IDX;
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                if (sts.key_eq || sts.key_gt)
                begin
                    cmd.set_pos = 1'b1;
                    cmd.hit_val = sts.key_eq;
                    state_next  = S_ACT;
                end
                else
                begin
                    cmd.idx_op = skt_pkg::IDX_INC;
                    state_next = S_SRCH_RD;
                end
            end
            // Act on the search outcome
            S_ACT:
            begin
                cmd.res_status = skt_pkg::ST_MISSING;
                state_next     = S_RESULT;
                case (sts.op)
                    skt_pkg::OP_INSERT:
                    begin
                        if (sts.hit)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = skt_pkg::ST_DUPLICATE;
                        end
                        else if (sts.full)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = skt_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.idx_op = skt_pkg::IDX_COUNT;
                            state_next = S_UP_RD;
                        end
                    end
                    skt_pkg::OP_MODIFY:
                    begin
                        cmd.res_load = 1'b1;
                        if (sts.hit)
                        begin
                            cmd.wr_en      = 1'b1;
                            cmd.res_status = skt_pkg::ST_DONE;
                        end
                    end
                    skt_pkg::OP_DELETE:
                    begin
                        if (sts.hit)
                        begin
                            cmd.idx_op = skt_pkg::IDX_POS;
                            state_next = S_DN_RD;
                        end
                        else
                        begin
                            cmd.res_load = 1'b1;
                        end
                    end
                    skt_pkg::OP_LOOKUP:
                    begin
                        cmd.res_load = 1'b1;
                        if (sts.hit)
                        begin
                            cmd.res_found  = 1'b1;
                            cmd.res_status = skt_pkg::ST_DONE;
                        end
                    end
                    default:
                    begin
                        cmd.res_load = 1'b1;
                    end
                endcase
            end
            // Open a slot: move entries up from the top down to the insert position
            S_UP_RD:
            begin
                if (sts.idx_at_pos)
                begin
                    cmd.wr_en      = 1'b1;
                    cmd.cnt_inc    = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = skt_pkg::ST_DONE;
                    state_next     = S_RESULT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = skt_pkg::RD_IDX_M1;
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_shift = 1'b1;
                cmd.idx_op   = skt_pkg::IDX_DEC;
                state_next   = S_UP_RD;
            end
            // Close the gap: move entries down over the deleted one
            S_DN_RD:
            begin
                if (sts.dn_last)
                begin
                    cmd.cnt_dec    = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = skt_pkg::ST_DONE;
                    state_next     = S_RESULT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = skt_pkg::RD_IDX_P1;
                    state_next = S_DN_WR;
                end
            end
            S_DN_WR:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_shift = 1'b1;
                cmd.idx_op   = skt_pkg::IDX_INC;
                state_next   = S_DN_RD;
            end
            // Hand the result to the output register once it is free
            S_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule
